FILE: rtl/core/multires_box_subtract_unit_assert.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef MULTIRES_BOX_SUBTRACT_UNIT_ASSERT_SVH
`define MULTIRES_BOX_SUBTRACT_UNIT_ASSERT_SVH

// same-cycle implication
`define MBS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MBS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/mbs_pkg.sv
package mbs_pkg;

  localparam int unsigned COORD_BITS_DEF  = 24;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned RES_BITS        = 5;
  localparam int unsigned NUM_AXES        = 3;
  localparam int unsigned NUM_SLABS       = 2 * NUM_AXES;
  localparam int unsigned SLAB_IDX_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 5;
  localparam int unsigned REG_IDX_W       = 3;

  localparam logic [REG_IDX_W-1:0] REG_CUT_LOW_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CUT_LOW_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CUT_LOW_Z  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CUT_SIZE_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CUT_SIZE_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CUT_SIZE_Z = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CUT_RES    = 3'd6;

  // how the back end treats a queued box
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_EMPTY,
    KIND_SLABS
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [NUM_SLABS-1:0] flags;
  } slab_ctl_t;

endpackage

FILE: rtl/core/mbs_box_if.sv
interface mbs_box_if #(
  parameter int unsigned COORD_BITS = mbs_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [COORD_BITS-1:0]         box_low_x;
  logic [COORD_BITS-1:0]         box_low_y;
  logic [COORD_BITS-1:0]         box_low_z;
  logic [COORD_BITS-1:0]         box_size_x;
  logic [COORD_BITS-1:0]         box_size_y;
  logic [COORD_BITS-1:0]         box_size_z;
  logic [mbs_pkg::RES_BITS-1:0]  box_res_x;
  logic [mbs_pkg::RES_BITS-1:0]  box_res_y;
  logic [mbs_pkg::RES_BITS-1:0]  box_res_z;

  modport source (
    output valid, box_low_x, box_low_y, box_low_z,
    output box_size_x, box_size_y, box_size_z, box_res_x, box_res_y, box_res_z,
    input  ready
  );

  modport sink (
    input  valid, box_low_x, box_low_y, box_low_z,
    input  box_size_x, box_size_y, box_size_z, box_res_x, box_res_y, box_res_z,
    output ready
  );
endinterface

FILE: rtl/core/mbs_piece_if.sv
interface mbs_piece_if #(
  parameter int unsigned COORD_BITS = mbs_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] piece_low_x;
  logic [COORD_BITS-1:0] piece_low_y;
  logic [COORD_BITS-1:0] piece_low_z;
  logic [COORD_BITS-1:0] piece_size_x;
  logic [COORD_BITS-1:0] piece_size_y;
  logic [COORD_BITS-1:0] piece_size_z;
  logic                  piece_valid;
  logic                  last_piece;

  modport source (
    output valid, piece_low_x, piece_low_y, piece_low_z,
    output piece_size_x, piece_size_y, piece_size_z, piece_valid, last_piece,
    input  ready
  );

  modport sink (
    input  valid, piece_low_x, piece_low_y, piece_low_z,
    input  piece_size_x, piece_size_y, piece_size_z, piece_valid, last_piece,
    output ready
  );
endinterface

FILE: rtl/core/multires_box_subtract_unit.sv
// Subtracts a configured cut box from each incoming 3-D box. The cut is rescaled per axis
// to the box's resolution (rounding up), then the box is returned whole when the two are
// disjoint, else as up to six slabs in the order x low, x high, y low, y high, z low, z high,
// with last_piece on the final one; an empty difference gives one beat with piece_valid 0.
// The front end registers the scaled bounds and classifies the box into a queue of
// QUEUE_DEPTH entries; the back end sends one piece per cycle from the output register,
// while piece_o.ready stays high. A box that yields n pieces (1 to 6) holds the back end
// until its last piece is sent; pass-through or empty boxes also go at one per cycle. A box
// moves through the front-end bounds, the queue, working registers and output register.
// Registers at byte address 4*i: cut_low_x/y/z, cut_size_x/y/z, then cut_res_packed
// (x bits 4:0, y 9:5, z 14:10); write them only while no box is in flight.
module multires_box_subtract_unit #(
  parameter int unsigned COORD_BITS  = mbs_pkg::COORD_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = mbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mbs_box_if.sink                        box_i,
  mbs_piece_if.source                    piece_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mbs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mbs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned NA = mbs_pkg::NUM_AXES;
  localparam int unsigned EW = 4 * NA * (COORD_BITS + 1);

  logic [NA-1:0][COORD_BITS-1:0]       cut_low, cut_size;
  logic [NA*mbs_pkg::RES_BITS-1:0]     cut_res;

  logic                                fr_valid, fr_ready;
  mbs_pkg::slab_ctl_t                  fr_ctl;
  logic [EW-1:0]                       fr_data;
  logic                                bk_valid, bk_ready;
  mbs_pkg::slab_ctl_t                  bk_ctl;
  logic [EW-1:0]                       bk_data;

  mbs_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cut_low_o  (cut_low),
    .cut_size_o (cut_size),
    .cut_res_o  (cut_res)
  );

  mbs_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .box_i         (box_i),
    .cut_low_i     (cut_low),
    .cut_size_i    (cut_size),
    .cut_res_i     (cut_res),
    .entry_valid_o (fr_valid),
    .entry_ready_i (fr_ready),
    .ctl_o         (fr_ctl),
    .data_o        (fr_data)
  );

  mbs_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_ctl_i   (fr_ctl),
    .wr_data_i  (fr_data),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_ctl_o   (bk_ctl),
    .rd_data_o  (bk_data)
  );

  mbs_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (bk_valid),
    .entry_ready_o (bk_ready),
    .ctl_i         (bk_ctl),
    .data_i        (bk_data),
    .piece_o       (piece_o)
  );

endmodule

FILE: rtl/core/mbs_cfg.sv
module mbs_cfg #(
  parameter int unsigned COORD_BITS = mbs_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [mbs_pkg::APB_ADDR_W-1:0]          paddr,
  input  logic [mbs_pkg::APB_DATA_W-1:0]          pwdata,
  output logic [mbs_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                    pready,
  output logic [mbs_pkg::NUM_AXES-1:0][COORD_BITS-1:0] cut_low_o,
  output logic [mbs_pkg::NUM_AXES-1:0][COORD_BITS-1:0] cut_size_o,
  output logic [mbs_pkg::NUM_AXES*mbs_pkg::RES_BITS-1:0] cut_res_o
);

  localparam int unsigned RES_W = mbs_pkg::NUM_AXES * mbs_pkg::RES_BITS;

  logic [mbs_pkg::NUM_AXES-1:0][COORD_BITS-1:0] cut_low_q;
  logic [mbs_pkg::NUM_AXES-1:0][COORD_BITS-1:0] cut_size_q;
  logic [RES_W-1:0]                             cut_res_q;
  logic [mbs_pkg::REG_IDX_W-1:0]                reg_idx;
  logic                                         wr_en;

  assign reg_idx = paddr[mbs_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_low_q  <= '0;
      cut_size_q <= '0;
      cut_res_q  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        mbs_pkg::REG_CUT_LOW_X:  cut_low_q[0]  <= pwdata[COORD_BITS-1:0];
        mbs_pkg::REG_CUT_LOW_Y:  cut_low_q[1]  <= pwdata[COORD_BITS-1:0];
        mbs_pkg::REG_CUT_LOW_Z:  cut_low_q[2]  <= pwdata[COORD_BITS-1:0];
        mbs_pkg::REG_CUT_SIZE_X: cut_size_q[0] <= pwdata[COORD_BITS-1:0];
        mbs_pkg::REG_CUT_SIZE_Y: cut_size_q[1] <= pwdata[COORD_BITS-1:0];
        mbs_pkg::REG_CUT_SIZE_Z: cut_size_q[2] <= pwdata[COORD_BITS-1:0];
        mbs_pkg::REG_CUT_RES:    cut_res_q     <= pwdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      mbs_pkg::REG_CUT_LOW_X:  prdata[COORD_BITS-1:0] = cut_low_q[0];
      mbs_pkg::REG_CUT_LOW_Y:  prdata[COORD_BITS-1:0] = cut_low_q[1];
      mbs_pkg::REG_CUT_LOW_Z:  prdata[COORD_BITS-1:0] = cut_low_q[2];
      mbs_pkg::REG_CUT_SIZE_X: prdata[COORD_BITS-1:0] = cut_size_q[0];
      mbs_pkg::REG_CUT_SIZE_Y: prdata[COORD_BITS-1:0] = cut_size_q[1];
      mbs_pkg::REG_CUT_SIZE_Z: prdata[COORD_BITS-1:0] = cut_size_q[2];
      mbs_pkg::REG_CUT_RES:    prdata[RES_W-1:0]      = cut_res_q;
      default:                 prdata = '0;
    endcase
  end

  assign cut_low_o  = cut_low_q;
  assign cut_size_o = cut_size_q;
  assign cut_res_o  = cut_res_q;

endmodule

FILE: rtl/core/mbs_front.sv
module mbs_front #(
  parameter int unsigned COORD_BITS = mbs_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  mbs_box_if.sink                                  box_i,
  input  logic [mbs_pkg::NUM_AXES-1:0][COORD_BITS-1:0] cut_low_i,
  input  logic [mbs_pkg::NUM_AXES-1:0][COORD_BITS-1:0] cut_size_i,
  input  logic [mbs_pkg::NUM_AXES*mbs_pkg::RES_BITS-1:0] cut_res_i,
  output logic                                     entry_valid_o,
  input  logic                                     entry_ready_i,
  output mbs_pkg::slab_ctl_t                       ctl_o,
  output logic [4*mbs_pkg::NUM_AXES*(COORD_BITS+1)-1:0] data_o
);

  localparam int unsigned BW = COORD_BITS + 1;
  localparam int unsigned NA = mbs_pkg::NUM_AXES;
  localparam int unsigned RB = mbs_pkg::RES_BITS;

  // bounds carry one extra bit: hi = lo + size and the cut's far corner can pass 2^COORD_BITS
  logic [NA-1:0][BW-1:0] lo_q, hi_q, c0_q, c1_q;
  logic [NA-1:0][BW-1:0] lo_d, hi_d, c0_d, c1_d;
  logic [NA-1:0][BW-1:0] t0, t1;
  logic [NA-1:0][RB-1:0] in_res, cut_res, shift;
  logic [NA-1:0][COORD_BITS-1:0] in_lo, in_size;
  logic                  s1_valid_q;
  logic                  in_ready;

  logic [NA-1:0][BW-1:0] lot, hit;
  logic [mbs_pkg::NUM_SLABS-1:0] flags;
  logic                  disjoint;

  // ceiling division by 2^d
  function automatic logic [BW-1:0] ceil_shift(input logic [BW-1:0] t,
                                               input logic [RB-1:0] d);
    logic [BW-1:0] rem_mask;
    rem_mask = ~({BW{1'b1}} << d);
    return (t >> d) + BW'(|(t & rem_mask));
  endfunction

  always_comb begin
    in_lo[0]   = box_i.box_low_x;
    in_lo[1]   = box_i.box_low_y;
    in_lo[2]   = box_i.box_low_z;
    in_size[0] = box_i.box_size_x;
    in_size[1] = box_i.box_size_y;
    in_size[2] = box_i.box_size_z;
    in_res[0]  = box_i.box_res_x;
    in_res[1]  = box_i.box_res_y;
    in_res[2]  = box_i.box_res_z;
    for (int a = 0; a < NA; a++) begin
      cut_res[a] = cut_res_i[a*RB +: RB];
      // cut coarser than box: no scaling
      shift[a]   = (cut_res[a] > in_res[a]) ? cut_res[a] - in_res[a] : '0;
      t0[a]      = {1'b0, cut_low_i[a]};
      t1[a]      = {1'b0, cut_low_i[a]} + {1'b0, cut_size_i[a]};
      c0_d[a]    = ceil_shift(t0[a], shift[a]);
      c1_d[a]    = ceil_shift(t1[a], shift[a]);
      lo_d[a]    = {1'b0, in_lo[a]};
      hi_d[a]    = {1'b0, in_lo[a]} + {1'b0, in_size[a]};
    end
  end

  assign in_ready    = !s1_valid_q || entry_ready_i;
  assign box_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= box_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && box_i.valid) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      c0_q <= c0_d;
      c1_q <= c1_d;
    end
  end

  // classify: disjoint pass-through, or which of the six slabs exist
  always_comb begin
    disjoint = 1'b0;
    flags    = '0;
    for (int a = 0; a < NA; a++) begin
      if ((c0_q[a] >= hi_q[a]) || (c1_q[a] <= lo_q[a])) begin
        disjoint = 1'b1;
      end
      flags[2*a] = (c0_q[a] > lo_q[a]) && (c0_q[a] < hi_q[a]);
      lot[a]     = flags[2*a] ? c0_q[a] : lo_q[a];
      flags[2*a+1] = (c1_q[a] > lot[a]) && (c1_q[a] < hi_q[a]);
      hit[a]     = flags[2*a+1] ? c1_q[a] : hi_q[a];
    end
  end

  always_comb begin
    ctl_o.flags = flags;
    if (disjoint) begin
      ctl_o.kind = mbs_pkg::KIND_PASS;
    end else if (flags == '0) begin
      ctl_o.kind = mbs_pkg::KIND_EMPTY;
    end else begin
      ctl_o.kind = mbs_pkg::KIND_SLABS;
    end
  end

  assign data_o        = {hit, lot, hi_q, lo_q};
  assign entry_valid_o = s1_valid_q;

endmodule

FILE: rtl/core/mbs_queue.sv
`include "multires_box_subtract_unit_assert.svh"

module mbs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = mbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  mbs_pkg::slab_ctl_t wr_ctl_i,
  input  logic [WIDTH-1:0]   wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output mbs_pkg::slab_ctl_t rd_ctl_o,
  output logic [WIDTH-1:0]   rd_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mbs_pkg::slab_ctl_t [DEPTH-1:0] ctl_q;
  logic [DEPTH-1:0][WIDTH-1:0]    data_q;
  logic [PTR_W-1:0]               wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]               count_q;
  logic                           push, pop;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_ctl_o   = ctl_q[rd_ptr_q];
  assign rd_data_o  = data_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wr_ptr_q]  <= wr_ctl_i;
      data_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `MBS_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))

endmodule

FILE: rtl/core/mbs_back.sv
`include "multires_box_subtract_unit_assert.svh"

module mbs_back #(
  parameter int unsigned COORD_BITS = mbs_pkg::COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               entry_valid_i,
  output logic               entry_ready_o,
  input  mbs_pkg::slab_ctl_t ctl_i,
  input  logic [4*mbs_pkg::NUM_AXES*(COORD_BITS+1)-1:0] data_i,
  mbs_piece_if.source        piece_o
);

  localparam int unsigned BW = COORD_BITS + 1;
  localparam int unsigned NA = mbs_pkg::NUM_AXES;
  localparam int unsigned NS = mbs_pkg::NUM_SLABS;
  localparam logic [NS-1:0] SLAB_LSB = NS'(1);

  // working box: original bounds and bounds after all trims
  logic [NA-1:0][BW-1:0]   lo_q, hi_q, lot_q, hit_q;
  logic [NA-1:0][BW-1:0]   lo_d, hi_d, lot_d, hit_d;
  logic                    work_valid_q;
  mbs_pkg::kind_e          kind_q;
  logic [NS-1:0]           mask_q;

  logic [mbs_pkg::SLAB_IDX_W-1:0] idx;
  logic                    found;
  logic [1:0]              axis;
  logic                    side;
  logic [NS-1:0]           rest;
  logic                    last;
  logic                    emit;
  logic                    pop;

  logic [NA-1:0][BW-1:0]   plo, phi;
  logic [NA-1:0][BW-1:0]   psize;
  logic                    pvalid;

  logic                    out_valid_q;
  logic [NA-1:0][COORD_BITS-1:0] low_q, size_q;
  logic                    piece_valid_q;
  logic                    last_piece_q;

  assign {hit_d, lot_d, hi_d, lo_d} = data_i;

  // next slab to send: lowest pending bit
  always_comb begin
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < NS; i++) begin
      if (mask_q[i] && !found) begin
        idx   = mbs_pkg::SLAB_IDX_W'(i);
        found = 1'b1;
      end
    end
  end

  assign axis = idx[2:1];
  assign side = idx[0];
  assign rest = mask_q & (mask_q - SLAB_LSB);
  assign last = (kind_q != mbs_pkg::KIND_SLABS) || (rest == '0);
  assign emit = work_valid_q && (!out_valid_q || piece_o.ready);
  assign entry_ready_o = !work_valid_q || (emit && last);
  assign pop  = entry_valid_i && entry_ready_o;

  always_comb begin
    pvalid = 1'b1;
    for (int b = 0; b < NA; b++) begin
      case (kind_q)
        mbs_pkg::KIND_PASS: begin
          plo[b] = lo_q[b];
          phi[b] = hi_q[b];
        end
        mbs_pkg::KIND_SLABS: begin
          // axes before this one are already trimmed, later ones are whole
          if (2'(b) < axis) begin
            plo[b] = lot_q[b];
            phi[b] = hit_q[b];
          end else if (2'(b) > axis) begin
            plo[b] = lo_q[b];
            phi[b] = hi_q[b];
          end else if (!side) begin
            plo[b] = lo_q[b];
            phi[b] = lot_q[b];
          end else begin
            plo[b] = hit_q[b];
            phi[b] = hi_q[b];
          end
        end
        default: begin
          plo[b] = '0;
          phi[b] = '0;
          pvalid = 1'b0;
        end
      endcase
      psize[b] = phi[b] - plo[b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      kind_q       <= mbs_pkg::KIND_EMPTY;
      mask_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop) begin
        work_valid_q <= 1'b1;
        kind_q       <= ctl_i.kind;
        mask_q       <= ctl_i.flags;
      end else if (emit && last) begin
        work_valid_q <= 1'b0;
      end else if (emit) begin
        mask_q <= rest;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (piece_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      lot_q <= lot_d;
      hit_q <= hit_d;
    end
    if (emit) begin
      for (int b = 0; b < NA; b++) begin
        low_q[b]  <= plo[b][COORD_BITS-1:0];
        size_q[b] <= psize[b][COORD_BITS-1:0];
      end
      piece_valid_q <= pvalid;
      last_piece_q  <= last;
    end
  end

  assign piece_o.valid        = out_valid_q;
  assign piece_o.piece_low_x  = low_q[0];
  assign piece_o.piece_low_y  = low_q[1];
  assign piece_o.piece_low_z  = low_q[2];
  assign piece_o.piece_size_x = size_q[0];
  assign piece_o.piece_size_y = size_q[1];
  assign piece_o.piece_size_z = size_q[2];
  assign piece_o.piece_valid  = piece_valid_q;
  assign piece_o.last_piece   = last_piece_q;

  `MBS_ASSERT_IMPL(a_slabs_pending, work_valid_q && (kind_q == mbs_pkg::KIND_SLABS), mask_q != '0)
  `MBS_ASSERT_NEXT(a_work_holds, emit && !last, work_valid_q)
  `MBS_ASSERT_IMPL(a_empty_is_last, out_valid_q && !piece_valid_q, last_piece_q)

endmodule
